// ===== rtl/core/descriptor_index_sequencer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// descriptor index sequencer assertion macros
// concurrent property helpers clocked on aclk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef DESCRIPTOR_INDEX_SEQUENCER_UNIT_ASSERT_SVH
`define DESCRIPTOR_INDEX_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication
`define DIS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DIS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dis_pkg.sv =====
// ----------------------------------------------------------------------------
// dis_pkg
// shared constants, types and tables of the descriptor index sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dis_pkg;

    localparam int MAX_RADIAL = 16;
    localparam int MAX_LMAX   = 7;

    localparam int NUM_LANES  = 9;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam int MAC_W      = 19;

    localparam logic [CFG_IDX_W-1:0] CFG_NSPECIES = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NMAX     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LMAX     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER    = 8'd3;

    localparam logic [3:0] LEV_PAIR = 4'd4;
    localparam logic [3:0] LEV_TRI  = 4'd9;

    typedef logic [4:0] lane_t;

    typedef struct packed {
        logic [MAC_W-1:0] a;
        logic [6:0]       b;
        logic [MAC_W-1:0] c;
    } mac_req_t;

    function automatic logic [7:0] sq(input logic [3:0] x);
        logic [7:0] r;
        case (x)
            4'd0:    r = 8'd0;
            4'd1:    r = 8'd1;
            4'd2:    r = 8'd4;
            4'd3:    r = 8'd9;
            4'd4:    r = 8'd16;
            4'd5:    r = 8'd25;
            4'd6:    r = 8'd36;
            4'd7:    r = 8'd49;
            4'd8:    r = 8'd64;
            4'd9:    r = 8'd81;
            4'd10:   r = 8'd100;
            4'd11:   r = 8'd121;
            4'd12:   r = 8'd144;
            4'd13:   r = 8'd169;
            4'd14:   r = 8'd196;
            default: r = 8'd225;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/descriptor_index_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// descriptor_index_sequencer_unit
// walks the index tuples of a pair or triple descriptor contraction
// ----------------------------------------------------------------------------
// Each input transaction (restart in s_tdata bit 0) yields at most one result
// transaction. The block takes one transaction at a time: it accepts it, loads
// the stored position, then searches the walk one level step at a time until it
// completes (the triangle and m-sum rules can send the search back a level),
// then runs the single shared multiply-add unit for the addresses and, for a
// triple, the m index, then runs a second search of the same kind to find the
// next position, and then hands the result to the output register, holding
// while that register waits on m_tready. An advance after the walk has ended
// gives no result.
`timescale 1ns / 1ps
`default_nettype none

module descriptor_index_sequencer_unit import dis_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // restart
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [87:0]           m_tdata,   // addr1 addr2 addr3 rad1 rad2 rad3 deg1 deg2 deg3
                                             // m_code group
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_SET1 = 3'd2;
    localparam logic [2:0] S_MAC  = 3'd3;
    localparam logic [2:0] S_SET2 = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam logic [3:0] STEP_PAIR_END = 4'd2;
    localparam logic [3:0] STEP_TRI_END  = 4'd12;

    logic [2:0]       state_reg;
    logic [4:0]       nspec_reg, nmax_reg;
    logic [2:0]       lmax_reg;
    logic             order_reg;
    logic             finished_reg;
    logic [17:0]      group_reg;
    logic [3:0]       st_reg [NUM_LANES];
    lane_t            v_reg [NUM_LANES];
    lane_t            prev_reg [NUM_LANES];
    logic [3:0]       k_reg;
    logic [3:0]       step_reg;
    logic [MAC_W-1:0] tmp_reg, acc_reg;
    logic [9:0]       addr_reg [3];
    logic [17:0]      grp_out_reg;
    logic             last_reg;
    logic             m_tvalid_reg;
    logic [87:0]      m_tdata_reg;
    logic             m_tlast_reg;

    logic [9:0]       nr_prod;
    logic [4:0]       nr;
    logic [2:0]       lm;
    logic [3:0]       lp1;
    logic [7:0]       nh_full;
    logic [6:0]       nh;
    logic [3:0]       nlev;
    logic             tri_mode;

    logic signed [6:0] vs [NUM_LANES];
    logic signed [6:0] nr_s, lm_s, lo, hi, vk, dd, ss, tt;
    lane_t             v_step [NUM_LANES];
    logic [3:0]        k_step;
    logic              fail;
    logic              keys_differ;

    mac_req_t          mreq;
    logic [MAC_W-1:0]  mres;
    logic [6:0]        a1, a2, a3;
    logic [3:0]        lane_sel;

    logic signed [5:0]  pdiff;
    logic [MAC_W-1:0]   pcode;
    logic [3:0]         rad_o [3];
    logic [2:0]         deg_o [3];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;

    assign tri_mode = order_reg;
    assign nlev     = tri_mode ? LEV_TRI : LEV_PAIR;
    assign nr_prod  = nspec_reg * nmax_reg;
    assign nr       = (nr_prod > 10'(MAX_RADIAL)) ? 5'(MAX_RADIAL) : nr_prod[4:0];
    assign lm       = (lmax_reg > 3'(MAX_LMAX)) ? 3'(MAX_LMAX) : lmax_reg;
    assign lp1      = {1'b0, lm} + 4'd1;
    assign nh_full  = sq(lp1);
    assign nh       = nh_full[6:0];
    assign nr_s     = $signed({2'b00, nr});
    assign lm_s     = $signed({4'b0000, lm});

    always_comb begin
        for (int j = 0; j < NUM_LANES; j++) begin
            vs[j] = $signed({2'b00, v_reg[j]});
        end
    end

    // bounds of the current walk level and one search step
    always_comb begin
        lo     = 7'sd0;
        hi     = -7'sd1;
        vk     = 7'sd0;
        fail   = 1'b0;
        k_step = k_reg;
        dd     = vs[3] - vs[4];
        ss     = vs[3] + vs[4];
        tt     = vs[3] + vs[4] + vs[5] - vs[6] - vs[7];
        for (int j = 0; j < NUM_LANES; j++) begin
            v_step[j] = v_reg[j];
            if (4'(j) == k_reg) begin
                vk = vs[j];
            end
        end
        case (k_reg)
            4'd0: hi = nr_s - 7'sd1;
            4'd1: begin
                lo = vs[0];
                hi = nr_s - 7'sd1;
            end
            4'd2: begin
                if (tri_mode) begin
                    lo = vs[1];
                    hi = nr_s - 7'sd1;
                end else begin
                    hi = lm_s;
                end
            end
            4'd3: hi = tri_mode ? lm_s : (vs[2] + vs[2]);
            4'd4: hi = lm_s;
            4'd5: begin
                lo = (dd < 7'sd0) ? -dd : dd;
                hi = (ss < lm_s) ? ss : lm_s;
            end
            4'd6: hi = vs[3] + vs[3];
            4'd7: hi = vs[4] + vs[4];
            4'd8: begin
                if (tt >= 7'sd0 && tt <= (vs[5] + vs[5])) begin
                    lo = tt;
                    hi = tt;
                end
            end
            default: ;
        endcase
        if (lo > hi || vk > hi) begin
            if (k_reg == 4'd0) begin
                fail = 1'b1;
            end else begin
                for (int j = 0; j < NUM_LANES; j++) begin
                    if (4'(j) >= k_reg) begin
                        v_step[j] = '0;
                    end else if (4'(j) + 4'd1 == k_reg) begin
                        v_step[j] = v_reg[j] + 5'd1;
                    end
                end
                k_step = k_reg - 4'd1;
            end
        end else begin
            if (vk < lo) begin
                for (int j = 0; j < NUM_LANES; j++) begin
                    if (4'(j) == k_reg) begin
                        v_step[j] = lo[4:0];
                    end else if (4'(j) > k_reg) begin
                        v_step[j] = '0;
                    end
                end
            end
            k_step = k_reg + 4'd1;
        end
    end

    always_comb begin
        keys_differ = 1'b0;
        for (int j = 0; j < 6; j++) begin
            if ((j < 3 || tri_mode) && v_reg[j] != prev_reg[j]) begin
                keys_differ = 1'b1;
            end
        end
    end

    // operand selection for the shared multiply-add unit
    assign a1 = {2'b00, v_reg[3]} + {2'b00, v_reg[3]} + 7'd1;
    assign a2 = {2'b00, v_reg[4]} + {2'b00, v_reg[4]} + 7'd1;
    assign a3 = {2'b00, v_reg[5]} + {2'b00, v_reg[5]} + 7'd1;
    assign lane_sel = {2'b00, step_reg[1:0]};

    always_comb begin
        mreq = '0;
        case (step_reg) inside
            4'd0, 4'd1, 4'd2: begin
                if (tri_mode) begin
                    mreq.a = MAC_W'(v_reg[lane_sel]);
                    mreq.b = nh;
                    mreq.c = MAC_W'(sq(v_reg[4'd3 + lane_sel][3:0]))
                           + MAC_W'(v_reg[4'd6 + lane_sel]);
                end else if (step_reg == 4'd0) begin
                    mreq.a = MAC_W'(v_reg[0]);
                    mreq.b = nh;
                    mreq.c = MAC_W'(sq(v_reg[2][3:0])) + MAC_W'(v_reg[3]);
                end else if (step_reg == 4'd1) begin
                    mreq.a = MAC_W'(v_reg[1]);
                    mreq.b = nh;
                    mreq.c = MAC_W'(sq(v_reg[2][3:0])) + MAC_W'(v_reg[2])
                           + MAC_W'(v_reg[2]) - MAC_W'(v_reg[3]);
                end
            end
            4'd3: begin
                mreq.a = MAC_W'(sq(v_reg[3][3:0]));
                mreq.b = nh;
            end
            4'd4: begin
                mreq.a = tmp_reg;
                mreq.b = nh;
            end
            4'd5: begin
                mreq.a = MAC_W'(sq(v_reg[4][3:0]));
                mreq.b = a1;
            end
            4'd6: begin
                mreq.a = tmp_reg;
                mreq.b = nh;
                mreq.c = acc_reg;
            end
            4'd7: begin
                mreq.a = MAC_W'(sq(v_reg[5][3:0]));
                mreq.b = a2;
            end
            4'd8: begin
                mreq.a = tmp_reg;
                mreq.b = a1;
                mreq.c = acc_reg;
            end
            4'd9: begin
                mreq.a = MAC_W'(v_reg[6]);
                mreq.b = a3;
            end
            4'd10: begin
                mreq.a = tmp_reg;
                mreq.b = a2;
                mreq.c = acc_reg;
            end
            4'd11: begin
                mreq.a = MAC_W'(v_reg[7]);
                mreq.b = a3;
                mreq.c = acc_reg;
            end
            4'd12: begin
                mreq.a = MAC_W'(v_reg[8]);
                mreq.b = 7'd1;
                mreq.c = acc_reg;
            end
            default: ;
        endcase
    end

    dis_mac u_mac (
        .req (mreq),
        .res (mres)
    );

    // result field assembly
    assign pdiff = $signed({1'b0, v_reg[3]}) - $signed({1'b0, v_reg[2]});
    always_comb begin
        if (!pdiff[0]) begin
            pcode = '0;
        end else if (pdiff < 6'sd0) begin
            pcode = '1;
        end else begin
            pcode = MAC_W'(1);
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            rad_o[j] = '0;
            deg_o[j] = '0;
        end
        if (tri_mode) begin
            for (int j = 0; j < 3; j++) begin
                rad_o[j] = prev_reg[j][3:0];
                deg_o[j] = prev_reg[3 + j][2:0];
            end
        end else begin
            rad_o[0] = prev_reg[0][3:0];
            rad_o[1] = prev_reg[1][3:0];
            deg_o[0] = prev_reg[2][2:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            nspec_reg    <= 5'd1;
            nmax_reg     <= 5'd1;
            lmax_reg     <= 3'd0;
            order_reg    <= 1'b1;
            finished_reg <= 1'b0;
            group_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            k_reg        <= '0;
            step_reg     <= '0;
            for (int j = 0; j < NUM_LANES; j++) begin
                st_reg[j] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_NSPECIES: nspec_reg <= cfg_data[4:0];
                    CFG_NMAX:     nmax_reg  <= cfg_data[4:0];
                    CFG_LMAX:     lmax_reg  <= cfg_data[2:0];
                    CFG_ORDER:    order_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (m_tvalid_reg && m_tready && state_reg != S_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        if (s_tdata[0]) begin
                            finished_reg <= 1'b0;
                            group_reg    <= '0;
                            for (int j = 0; j < NUM_LANES; j++) begin
                                st_reg[j] <= '0;
                            end
                        end
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    k_reg     <= '0;
                    state_reg <= finished_reg ? S_IDLE : S_SET1;
                end
                S_SET1: begin
                    if (k_reg == nlev) begin
                        step_reg  <= '0;
                        state_reg <= S_MAC;
                    end else if (fail) begin
                        finished_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end else begin
                        k_reg <= k_step;
                    end
                end
                S_MAC: begin
                    if (step_reg == (tri_mode ? STEP_TRI_END : STEP_PAIR_END)) begin
                        k_reg     <= '0;
                        state_reg <= S_SET2;
                    end else begin
                        step_reg <= step_reg + 4'd1;
                    end
                end
                S_SET2: begin
                    if (k_reg == nlev) begin
                        for (int j = 0; j < NUM_LANES; j++) begin
                            if (tri_mode || j == 0 || j == 1) begin
                                st_reg[j] <= v_reg[j][3:0];
                            end else if (j == 3) begin
                                st_reg[j] <= v_reg[2][3:0];
                            end else if (j == 6) begin
                                st_reg[j] <= v_reg[3][3:0];
                            end else begin
                                st_reg[j] <= '0;
                            end
                        end
                        if (keys_differ) begin
                            group_reg <= group_reg + 18'd1;
                        end
                        state_reg <= S_OUT;
                    end else if (fail) begin
                        finished_reg <= 1'b1;
                        for (int j = 0; j < NUM_LANES; j++) begin
                            st_reg[j] <= '0;
                        end
                        state_reg <= S_OUT;
                    end else begin
                        k_reg <= k_step;
                    end
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_LOAD: begin
                for (int j = 0; j < NUM_LANES; j++) begin
                    if (tri_mode || j == 0 || j == 1) begin
                        v_reg[j] <= {1'b0, st_reg[j]};
                    end else if (j == 2) begin
                        v_reg[j] <= {1'b0, st_reg[3]};
                    end else if (j == 3) begin
                        v_reg[j] <= {1'b0, st_reg[6]};
                    end else begin
                        v_reg[j] <= '0;
                    end
                end
            end
            S_SET1: begin
                if (k_reg != nlev && !fail) begin
                    for (int j = 0; j < NUM_LANES; j++) begin
                        v_reg[j] <= v_step[j];
                    end
                end
            end
            S_MAC: begin
                case (step_reg) inside
                    4'd0, 4'd1, 4'd2:       addr_reg[step_reg[1:0]] <= mres[9:0];
                    4'd3, 4'd5, 4'd7, 4'd9: tmp_reg <= mres;
                    default:                acc_reg <= mres;
                endcase
                if (step_reg == (tri_mode ? STEP_TRI_END : STEP_PAIR_END)) begin
                    for (int j = 0; j < NUM_LANES; j++) begin
                        prev_reg[j] <= v_reg[j];
                    end
                    if (tri_mode) begin
                        v_reg[8] <= v_reg[8] + 5'd1;
                    end else begin
                        v_reg[3] <= v_reg[3] + 5'd1;
                    end
                    grp_out_reg <= group_reg;
                    if (!tri_mode) begin
                        acc_reg <= pcode;
                    end
                end
            end
            S_SET2: begin
                last_reg <= (k_reg != nlev) && fail;
                if (k_reg != nlev && !fail) begin
                    for (int j = 0; j < NUM_LANES; j++) begin
                        v_reg[j] <= v_step[j];
                    end
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_reg <= {grp_out_reg, acc_reg,
                                    deg_o[2], deg_o[1], deg_o[0],
                                    rad_o[2], rad_o[1], rad_o[0],
                                    tri_mode ? addr_reg[2] : 10'd0,
                                    addr_reg[1], addr_reg[0]};
                    m_tlast_reg <= last_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/dis_mac.sv =====
// ----------------------------------------------------------------------------
// dis_mac
// shared multiply-add unit: res = a * b + c, modulo 2^19
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dis_mac import dis_pkg::*; (
    input  mac_req_t         req,
    output logic [MAC_W-1:0] res
);

    logic [MAC_W+6:0] prod;

    assign prod = req.a * req.b;
    assign res  = prod[MAC_W-1:0] + req.c;

endmodule

`default_nettype wire

// ===== rtl/core/dis_checker.sv =====
// ----------------------------------------------------------------------------
// dis_checker
// port-level checks of the descriptor index sequencer, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "descriptor_index_sequencer_unit_assert.svh"

module dis_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [87:0] m_tdata,
    input wire logic        m_tlast
);

    // block is busy right after taking a transaction
    `DIS_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")

    // a stalled result holds
    `DIS_ASSERT_NXT(a_result_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "data moved")
    `DIS_ASSERT_NXT(a_last_hold, m_tvalid && !m_tready, $stable(m_tlast), "last moved")

    // radial indices come out ordered
    `DIS_ASSERT_IMP(a_rad_order, m_tvalid, m_tdata[33:30] <= m_tdata[37:34], "rad1 above rad2")

endmodule

bind descriptor_index_sequencer_unit dis_checker u_dis_checker (.*);

`default_nettype wire
